/* rtl/dpts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decaying-priority task scheduler package
// Shared constants, codes and the structs that run between the top level and
// the row of task cells.
// ----------------------------------------------------------------------------
package dpts_pkg;

   // Task table size and the widths that follow from it.
   localparam int MAX_TASKS  = 8;
   localparam int TASK_IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int COUNT_W    = $clog2(MAX_TASKS + 1);
   localparam int TARGET_W   = (TASK_IDX_W > 3) ? TASK_IDX_W : 3;

   // Base priority and credit of the task that exists after reset.
   localparam logic [7:0] FIRST_PRIORITY = 8'd5;

   // Transaction kinds.
   localparam logic [2:0] KIND_CREATE = 3'd0;
   localparam logic [2:0] KIND_YIELD  = 3'd1;
   localparam logic [2:0] KIND_WAIT   = 3'd2;
   localparam logic [2:0] KIND_RESUME = 3'd3;
   localparam logic [2:0] KIND_TICK   = 3'd4;

   // Task state codes.
   localparam logic [2:0] TS_UNINIT  = 3'd0;
   localparam logic [2:0] TS_ACTIVE  = 3'd1;
   localparam logic [2:0] TS_WAIT    = 3'd2;
   localparam logic [2:0] TS_SUSPEND = 3'd3;
   localparam logic [2:0] TS_STOPPED = 3'd4;

   // Operations broadcast to the cells.
   localparam logic [2:0] OP_NONE   = 3'd0;
   localparam logic [2:0] OP_CREATE = 3'd1;
   localparam logic [2:0] OP_YIELD  = 3'd2;
   localparam logic [2:0] OP_WAIT   = 3'd3;
   localparam logic [2:0] OP_RESUME = 3'd4;
   localparam logic [2:0] OP_TICK   = 3'd5;

   // Command broadcast to every cell in the execute cycle.
   typedef struct packed {
      logic [2:0]            op;
      logic                  sched;
      logic                  reload;
      logic [TASK_IDX_W-1:0] held;
      logic [TARGET_W-1:0]   target;
      logic [7:0]            priority_val;
      logic [2:0]            status;
      logic [15:0]           delay;
   } cmd_type;

   // Search record that travels one cell per cycle.
   typedef struct packed {
      logic                  valid;
      logic                  hit;
      logic                  have;
      logic [7:0]            best;
      logic [TASK_IDX_W-1:0] sel;
   } scan_type;

   // Per-cell status seen by the top level.
   typedef struct packed {
      logic stopped;
      logic credit_one;
   } flag_type;

endpackage

/* rtl/dpts_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task cell
// Holds one entry of the task table, applies broadcast commands to it and
// advances the search record by one step toward the next cell.
// ----------------------------------------------------------------------------
module dpts_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [dpts_pkg::TASK_IDX_W-1:0]   cell_idx,
   input  dpts_pkg::cmd_type                 cmd,
   input  dpts_pkg::scan_type                scan_in,
   output dpts_pkg::scan_type                scan_out,
   output dpts_pkg::flag_type                flags
);
   import dpts_pkg::*;

   logic [7:0]  base_ff, base_in;
   logic [7:0]  credit_ff, credit_in;
   logic [2:0]  state_ff, state_in;
   logic [15:0] wait_ff, wait_in;
   logic        excl_ff, excl_in;
   logic        scan_valid_ff;
   scan_type    scan_ff, scan_in_next;
   logic        is_held;
   logic        is_target;

   assign is_held   = (cmd.held == cell_idx);
   assign is_target = (cmd.target == TARGET_W'(cell_idx));

   // Apply the broadcast command to this entry.
   always_comb begin
      base_in   = base_ff;
      credit_in = credit_ff;
      state_in  = state_ff;
      wait_in   = wait_ff;
      excl_in   = excl_ff;
      case (cmd.op)
         OP_CREATE: begin
            if (is_target) begin
               base_in   = cmd.priority_val;
               credit_in = cmd.priority_val;
               state_in  = cmd.status;
            end
         end
         OP_YIELD: begin
            excl_in = is_held && (state_ff != TS_STOPPED);
            if (is_held && (state_ff != TS_STOPPED)) begin
               state_in = TS_ACTIVE;
            end
         end
         OP_WAIT: begin
            excl_in = 1'b0;
            if (is_held) begin
               state_in = TS_WAIT;
               wait_in  = cmd.delay;
            end
         end
         OP_RESUME: begin
            if (is_target && (state_ff == TS_STOPPED)) begin
               state_in = cmd.status;
            end
         end
         OP_TICK: begin
            if (wait_ff != 16'd0) begin
               wait_in = wait_ff - 16'd1;
            end
         end
         default: begin
         end
      endcase
      // Credit decay of the running task, with a refill from base priority.
      if (cmd.sched) begin
         if (cmd.reload) begin
            credit_in = base_ff;
         end else if (is_held) begin
            credit_in = credit_ff - 8'd1;
         end
      end
   end

   // One search step: the first ready waiter wins, else the latest best credit.
   always_comb begin
      scan_in_next = scan_in;
      if (!scan_in.hit) begin
         if ((state_ff == TS_WAIT) && (wait_ff == 16'd0)) begin
            scan_in_next.hit = 1'b1;
            scan_in_next.sel = cell_idx;
         end else if ((state_ff == TS_ACTIVE) && !excl_ff &&
                      (credit_ff >= scan_in.best)) begin
            scan_in_next.have = 1'b1;
            scan_in_next.best = credit_ff;
            scan_in_next.sel  = cell_idx;
         end
      end
   end

   // Table entry and search record valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff       <= (cell_idx == '0) ? FIRST_PRIORITY : 8'd0;
         credit_ff     <= (cell_idx == '0) ? FIRST_PRIORITY : 8'd0;
         state_ff      <= (cell_idx == '0) ? TS_ACTIVE : TS_UNINIT;
         wait_ff       <= 16'd0;
         excl_ff       <= 1'b0;
         scan_valid_ff <= 1'b0;
      end else begin
         base_ff       <= base_in;
         credit_ff     <= credit_in;
         state_ff      <= state_in;
         wait_ff       <= wait_in;
         excl_ff       <= excl_in;
         scan_valid_ff <= scan_in.valid;
      end
   end

   // Search record payload.
   always_ff @(posedge clock) begin
      scan_ff <= scan_in_next;
   end

   always_comb begin
      scan_out       = scan_ff;
      scan_out.valid = scan_valid_ff;
   end

   assign flags.stopped    = (state_ff == TS_STOPPED);
   assign flags.credit_one = (credit_ff == 8'd1);

endmodule

/* rtl/decaying_priority_task_scheduler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decaying-priority task scheduler
// Task table held in a row of cells, with a search record that walks the row.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its result shows
// on the rsp_ ports for one cycle with rsp_valid and cannot be held off.
// Create, resume, tick and the first yield or wait run only the execute state;
// the result is shown in the cycle in which busy falls. Later yield and wait
// transactions also run the scheduler search, whose record moves through one
// task cell per cycle, and busy stays high until the record leaves the last
// cell. A new transaction can be started in the cycle in which the previous
// result is shown.
// ----------------------------------------------------------------------------
module decaying_priority_task_scheduler (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_kind,
   input  logic [7:0]  req_priority_req,
   input  logic [2:0]  req_status,
   input  logic [15:0] req_delay_ticks,
   input  logic [2:0]  req_task_index,
   output logic        rsp_valid,
   output logic [2:0]  rsp_running_task,
   output logic        rsp_accepted,
   output logic [3:0]  rsp_task_count,
   output logic [31:0] rsp_system_time
);
   import dpts_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;

   logic [1:0]            fsm_ff, fsm_in;
   logic [2:0]            kind_ff, kind_in;
   logic [7:0]            pri_ff, pri_in;
   logic [2:0]            status_ff, status_in;
   logic [15:0]           delay_ff, delay_in;
   logic [2:0]            index_ff, index_in;
   logic [COUNT_W-1:0]    created_ff, created_in;
   logic [TASK_IDX_W-1:0] current_ff, current_in;
   logic                  started_ff, started_in;
   logic [31:0]           time_ff, time_in;
   logic                  scan_start_ff, scan_start_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [2:0]            rsp_task_ff, rsp_task_in;
   logic                  rsp_acc_ff, rsp_acc_in;
   logic [3:0]            rsp_count_ff, rsp_count_in;
   logic [31:0]           rsp_time_ff, rsp_time_in;

   cmd_type               cmd;
   scan_type              chain [0:MAX_TASKS];
   flag_type              flags [0:MAX_TASKS-1];
   logic                  reload_hit;
   logic                  resume_hit;
   logic                  can_create;
   logic                  exec_acc;
   logic                  is_exec;
   logic                  scan_done;

   // Row of task cells linked by the search record.
   assign chain[0] = '{valid: scan_start_ff, hit: 1'b0, have: 1'b0,
                       best: 8'd0, sel: '0};

   for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
      dpts_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (TASK_IDX_W'(g)),
         .cmd      (cmd),
         .scan_in  (chain[g]),
         .scan_out (chain[g+1]),
         .flags    (flags[g])
      );
   end

   assign is_exec    = (fsm_ff == S_EXEC);
   assign scan_done  = (fsm_ff == S_SCAN) && chain[MAX_TASKS].valid;
   assign can_create = (32'(created_ff) < MAX_TASKS);

   // Status of the running task and of the resume target.
   always_comb begin
      reload_hit = 1'b0;
      resume_hit = 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) begin
         if (TASK_IDX_W'(i) == current_ff) begin
            reload_hit = reload_hit | flags[i].credit_one;
         end
         if (TARGET_W'(i) == TARGET_W'(index_ff)) begin
            resume_hit = resume_hit | flags[i].stopped;
         end
      end
   end

   // Decode the latched transaction into a broadcast command.
   always_comb begin
      cmd              = '0;
      cmd.held         = current_ff;
      cmd.priority_val = pri_ff;
      cmd.status       = status_ff;
      cmd.delay        = delay_ff;
      cmd.target       = TARGET_W'(index_ff);
      exec_acc         = 1'b0;
      if (is_exec) begin
         case (kind_ff)
            KIND_CREATE: begin
               cmd.target = TARGET_W'(created_ff);
               cmd.op     = can_create ? OP_CREATE : OP_NONE;
               exec_acc   = can_create;
            end
            KIND_YIELD: begin
               cmd.op    = OP_YIELD;
               cmd.sched = started_ff;
               exec_acc  = 1'b1;
            end
            KIND_WAIT: begin
               cmd.op    = OP_WAIT;
               cmd.sched = started_ff;
               exec_acc  = 1'b1;
            end
            KIND_RESUME: begin
               cmd.op   = OP_RESUME;
               exec_acc = resume_hit;
            end
            KIND_TICK: begin
               cmd.op   = OP_TICK;
               exec_acc = 1'b1;
            end
            default: begin
               cmd.op = OP_NONE;
            end
         endcase
      end
      cmd.reload = cmd.sched & reload_hit;
   end

   // Sequencer and global counters.
   always_comb begin
      fsm_in        = fsm_ff;
      kind_in       = kind_ff;
      pri_in        = pri_ff;
      status_in     = status_ff;
      delay_in      = delay_ff;
      index_in      = index_ff;
      created_in    = created_ff;
      current_in    = current_ff;
      started_in    = started_ff;
      time_in       = time_ff;
      scan_start_in = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_acc_in    = rsp_acc_ff;
      case (fsm_ff)
         S_IDLE: begin
            if (start) begin
               fsm_in    = S_EXEC;
               kind_in   = req_kind;
               pri_in    = req_priority_req;
               status_in = req_status;
               delay_in  = req_delay_ticks;
               index_in  = req_task_index;
            end
         end
         S_EXEC: begin
            if ((kind_ff == KIND_CREATE) && can_create) begin
               created_in = created_ff + COUNT_W'(1);
            end
            if (kind_ff == KIND_TICK) begin
               time_in = time_ff + 32'd1;
            end
            if ((kind_ff == KIND_YIELD) || (kind_ff == KIND_WAIT)) begin
               started_in = 1'b1;
            end
            if (cmd.sched) begin
               fsm_in        = S_SCAN;
               scan_start_in = 1'b1;
            end else begin
               fsm_in       = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_acc_in   = exec_acc;
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               fsm_in       = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_acc_in   = 1'b1;
               if (chain[MAX_TASKS].hit || chain[MAX_TASKS].have) begin
                  current_in = chain[MAX_TASKS].sel;
               end
            end
         end
         default: begin
            fsm_in = S_IDLE;
         end
      endcase
      rsp_task_in  = 3'(current_in);
      rsp_count_in = 4'(created_in);
      rsp_time_in  = time_in;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff        <= S_IDLE;
         created_ff    <= COUNT_W'(1);
         current_ff    <= '0;
         started_ff    <= 1'b0;
         time_ff       <= 32'd0;
         scan_start_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         fsm_ff        <= fsm_in;
         created_ff    <= created_in;
         current_ff    <= current_in;
         started_ff    <= started_in;
         time_ff       <= time_in;
         scan_start_ff <= scan_start_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Latched transaction and result payload.
   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      pri_ff       <= pri_in;
      status_ff    <= status_in;
      delay_ff     <= delay_in;
      index_ff     <= index_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_task_ff  <= rsp_task_in;
      rsp_count_ff <= rsp_count_in;
      rsp_time_ff  <= rsp_time_in;
   end

   assign busy             = (fsm_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_running_task = rsp_task_ff;
   assign rsp_accepted     = rsp_acc_ff;
   assign rsp_task_count   = rsp_count_ff;
   assign rsp_system_time  = rsp_time_ff;

endmodule

/* rtl/dpts_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler port checker
// Checks the command handshake and result strobe seen at the top-level ports.
// ----------------------------------------------------------------------------
module dpts_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // A taken transaction makes the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("Block not busy after a transaction was taken.");

   // The result strobe lasts exactly one cycle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("Result strobe held for more than one cycle.");

   // A result is shown only once the block has gone idle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("Result shown while the block is still busy.");

   // Every finished transaction produces a result.
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("Transaction finished without a result.");

endmodule

bind decaying_priority_task_scheduler dpts_checker u_dpts_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decaying-priority task scheduler testbench
// Sends create, yield, wait, resume, tick and undefined transactions, first a
// directed set and then a long random mix, and checks every result against
// a local model of the task table. Sender idling changes from phase to phase.
// ----------------------------------------------------------------------------
module testbench;
   import dpts_pkg::*;

   localparam int CLOCK_PERIOD = 4;
   localparam int RESET_CYCLES = 11;
   localparam int RANDOM_SCHEDULER_ITEMS = 1500;
   localparam int PHASE_LENGTH = 150;
   localparam int DRAIN_CYCLES = MAX_TASKS + 12;
   localparam int CYCLE_LIMIT = 400000;
   localparam int REPORT_LIMIT = 10;

   // Codes beyond the named kinds and states, which the block must tolerate.
   localparam logic [2:0] KIND_MAX_CODE = 3'd7;
   localparam logic [2:0] STATE_MAX_CODE = 3'd7;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  prio;
      logic [2:0]  status;
      logic [15:0] delay;
      logic [2:0]  index;
   } sched_cmd_type;

   typedef struct packed {
      logic [2:0]  running;
      logic        accepted;
      logic [3:0]  count;
      logic [31:0] sys_time;
   } sched_outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_kind = KIND_TICK;
   logic [7:0]  req_priority_req = 8'd0;
   logic [2:0]  req_status = TS_UNINIT;
   logic [15:0] req_delay_ticks = 16'd0;
   logic [2:0]  req_task_index = 3'd0;
   logic        rsp_valid;
   logic [2:0]  rsp_running_task;
   logic        rsp_accepted;
   logic [3:0]  rsp_task_count;
   logic [31:0] rsp_system_time;

   sched_cmd_type     commands_to_send[$];
   sched_outcome_type outcomes_due[$];
   int                items_taken = 0;
   int                results_seen = 0;
   int                mismatch_count = 0;
   int                cycle_count = 0;

   // Local copy of the task table.
   logic [7:0]  prio_tab[MAX_TASKS];
   logic [7:0]  credit_tab[MAX_TASKS];
   logic [2:0]  state_tab[MAX_TASKS];
   logic [15:0] wait_tab[MAX_TASKS];
   int unsigned task_total;
   int unsigned cur_task;
   bit          sched_started;
   logic [31:0] tick_total;

   decaying_priority_task_scheduler DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_kind(req_kind),
      .req_priority_req(req_priority_req),
      .req_status(req_status),
      .req_delay_ticks(req_delay_ticks),
      .req_task_index(req_task_index),
      .rsp_valid(rsp_valid),
      .rsp_running_task(rsp_running_task),
      .rsp_accepted(rsp_accepted),
      .rsp_task_count(rsp_task_count),
      .rsp_system_time(rsp_system_time)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Table contents after reset: only task 0 exists.
   function automatic void clear_task_table();
      for (int i = 0; i < MAX_TASKS; i++) begin
         prio_tab[i] = 8'd0;
         credit_tab[i] = 8'd0;
         state_tab[i] = TS_UNINIT;
         wait_tab[i] = 16'd0;
      end
      prio_tab[0] = FIRST_PRIORITY;
      credit_tab[0] = FIRST_PRIORITY;
      state_tab[0] = TS_ACTIVE;
      task_total = 1;
      cur_task = 0;
      sched_started = 1'b0;
      tick_total = 32'd0;
   endfunction

   // Charge the running task one credit and pick the next; first call: no-op.
   function automatic void pick_next_task();
      logic [7:0]  best;
      int unsigned held;
      bit          excluded;
      best = 8'd0;
      held = cur_task;
      excluded = 1'b0;
      if (!sched_started) begin
         sched_started = 1'b1;
         return;
      end
      credit_tab[held] = credit_tab[held] - 8'd1;
      if (credit_tab[held] == 8'd0) begin
         for (int i = 0; i < task_total; i++)
            credit_tab[i] = prio_tab[i];
      end
      // An active running task sits out its own search.
      if (state_tab[held] == TS_ACTIVE) begin
         state_tab[held] = TS_SUSPEND;
         excluded = 1'b1;
      end
      // A waiting task whose delay has run out wins at once; otherwise the
      // last active task with the highest credit is taken.
      for (int i = 0; i < task_total; i++) begin
         if (wait_tab[i] == 16'd0 && state_tab[i] == TS_WAIT) begin
            cur_task = i;
            break;
         end
         if (state_tab[i] == TS_ACTIVE && credit_tab[i] >= best) begin
            best = credit_tab[i];
            cur_task = i;
         end
      end
      if (excluded)
         state_tab[held] = TS_ACTIVE;
   endfunction

   // Apply one transaction to the table and return the result it must give.
   function automatic sched_outcome_type next_schedule_outcome(input sched_cmd_type c);
      sched_outcome_type r;
      r.accepted = 1'b0;
      case (c.kind)
         KIND_CREATE: begin
            if (task_total < MAX_TASKS) begin
               prio_tab[task_total] = c.prio;
               credit_tab[task_total] = c.prio;
               state_tab[task_total] = c.status;
               task_total++;
               r.accepted = 1'b1;
            end
         end
         KIND_YIELD: begin
            if (state_tab[cur_task] != TS_STOPPED)
               state_tab[cur_task] = TS_ACTIVE;
            pick_next_task();
            r.accepted = 1'b1;
         end
         KIND_WAIT: begin
            state_tab[cur_task] = TS_WAIT;
            wait_tab[cur_task] = c.delay;
            pick_next_task();
            r.accepted = 1'b1;
         end
         KIND_RESUME: begin
            if (c.index < MAX_TASKS && state_tab[c.index] == TS_STOPPED) begin
               state_tab[c.index] = c.status;
               r.accepted = 1'b1;
            end
         end
         KIND_TICK: begin
            tick_total = tick_total + 32'd1;
            for (int i = 0; i < MAX_TASKS; i++) begin
               if (wait_tab[i] != 16'd0)
                  wait_tab[i] = wait_tab[i] - 16'd1;
            end
            r.accepted = 1'b1;
         end
         default: ;
      endcase
      r.running = cur_task[2:0];
      r.count = task_total[3:0];
      r.sys_time = tick_total;
      return r;
   endfunction

   function automatic void queue_command(input logic [2:0] kind, input logic [7:0] prio,
                                         input logic [2:0] status, input logic [15:0] delay,
                                         input logic [2:0] index);
      sched_cmd_type c;
      c.kind = kind;
      c.prio = prio;
      c.status = status;
      c.delay = delay;
      c.index = index;
      commands_to_send.push_back(c);
   endfunction

   // Reset is held once, at the start, and then released.
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
   end

   // Sender: takes transactions from the pending queue; idling depends on the
   // phase, which advances with the number of transactions taken.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) begin
            outcomes_due.push_back(next_schedule_outcome(commands_to_send[0]));
            void'(commands_to_send.pop_front());
            items_taken++;
         end
         if (commands_to_send.size() != 0 &&
             $urandom_range(99) >= (((items_taken / PHASE_LENGTH) % 4 == 1) ? 73 :
                                    ((items_taken / PHASE_LENGTH) % 4 == 3) ? 22 : 0)) begin
            req_kind <= commands_to_send[0].kind;
            req_priority_req <= commands_to_send[0].prio;
            req_status <= commands_to_send[0].status;
            req_delay_ticks <= commands_to_send[0].delay;
            req_task_index <= commands_to_send[0].index;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Receiver: every strobed result is matched against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         results_seen++;
         if (outcomes_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("Unexpected result %0d: task %0d accepted %0b count %0d time %0d",
                        results_seen, rsp_running_task, rsp_accepted, rsp_task_count,
                        rsp_system_time);
         end else begin
            if (rsp_running_task !== outcomes_due[0].running ||
                rsp_accepted !== outcomes_due[0].accepted ||
                rsp_task_count !== outcomes_due[0].count ||
                rsp_system_time !== outcomes_due[0].sys_time) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("Mismatch on result %0d: expected task %0d accepted %0b %s",
                           results_seen, outcomes_due[0].running,
                           outcomes_due[0].accepted, "");
                  $display("   expected count %0d time %0d", outcomes_due[0].count,
                           outcomes_due[0].sys_time);
                  $display("   got task %0d accepted %0b count %0d time %0d",
                           rsp_running_task, rsp_accepted, rsp_task_count,
                           rsp_system_time);
               end
            end
            void'(outcomes_due.pop_front());
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL decaying_priority_task_scheduler");
         $finish;
      end
   end

   // Stimulus and end of run.
   initial begin
      int            counted;
      int            roll;
      sched_cmd_type c;
      clear_task_table();

      // Directed part: fill the table with every kind of task, overflow it,
      // then walk through the scheduling and resume corner cases.
      queue_command(KIND_YIELD, 8'd0, TS_UNINIT, 16'd0, 3'd0);
      queue_command(KIND_CREATE, 8'd255, TS_ACTIVE, 16'hFFFF, 3'd7);
      queue_command(KIND_CREATE, 8'd0, TS_ACTIVE, 16'd0, 3'd0);
      queue_command(KIND_CREATE, 8'd3, TS_WAIT, 16'd0, 3'd0);
      queue_command(KIND_CREATE, 8'd128, TS_STOPPED, 16'd0, 3'd0);
      queue_command(KIND_CREATE, 8'd7, TS_SUSPEND, 16'd0, 3'd0);
      queue_command(KIND_CREATE, 8'd1, STATE_MAX_CODE, 16'd0, 3'd0);
      queue_command(KIND_CREATE, 8'd90, TS_STOPPED, 16'd0, 3'd0);
      queue_command(KIND_CREATE, 8'd200, TS_ACTIVE, 16'd0, 3'd0);
      queue_command(KIND_YIELD, 8'd0, TS_UNINIT, 16'd0, 3'd0);
      queue_command(KIND_YIELD, 8'd0, TS_UNINIT, 16'd0, 3'd0);
      queue_command(KIND_RESUME, 8'd0, TS_ACTIVE, 16'd0, 3'd1);
      queue_command(KIND_RESUME, 8'd0, TS_ACTIVE, 16'd0, 3'd4);
      queue_command(KIND_RESUME, 8'd0, TS_STOPPED, 16'd0, 3'd7);
      queue_command(KIND_RESUME, 8'd0, TS_ACTIVE, 16'd0, 3'd6);
      queue_command(KIND_WAIT, 8'd0, TS_UNINIT, 16'd2, 3'd0);
      queue_command(KIND_TICK, 8'hFF, STATE_MAX_CODE, 16'hFFFF, 3'd7);
      queue_command(KIND_TICK, 8'd0, TS_UNINIT, 16'd0, 3'd0);
      queue_command(KIND_TICK, 8'd0, TS_UNINIT, 16'd0, 3'd0);
      queue_command(KIND_YIELD, 8'd0, TS_UNINIT, 16'd0, 3'd0);
      queue_command(KIND_TICK + 3'd1, 8'd0, TS_UNINIT, 16'd0, 3'd0);
      queue_command(KIND_MAX_CODE, 8'hFF, STATE_MAX_CODE, 16'hFFFF, 3'd7);
      queue_command(KIND_WAIT, 8'd0, TS_UNINIT, 16'd0, 3'd0);
      queue_command(KIND_YIELD, 8'd0, TS_UNINIT, 16'd0, 3'd0);
      queue_command(KIND_YIELD, 8'd0, TS_UNINIT, 16'd0, 3'd0);

      // Random part: yields and waits make up half the items, with short waits
      // and plenty of ticks so that waiting tasks come back; fields a kind
      // does not use carry random values.
      counted = 0;
      while (counted < RANDOM_SCHEDULER_ITEMS) begin
         c.prio = 8'($urandom_range(255));
         c.status = 3'($urandom_range(STATE_MAX_CODE));
         c.delay = 16'($urandom_range(16'hFFFF));
         c.index = 3'($urandom_range(MAX_TASKS - 1));
         roll = $urandom_range(99);
         if (roll < 30) begin
            c.kind = KIND_YIELD;
         end else if (roll < 50) begin
            c.kind = KIND_WAIT;
            if ($urandom_range(99) >= 3)
               c.delay = 16'($urandom_range(6));
         end else if (roll < 75) begin
            c.kind = KIND_TICK;
         end else if (roll < 88) begin
            // Resume often leaves the task stopped so the stopped pool lasts.
            c.kind = KIND_RESUME;
            roll = $urandom_range(99);
            if (roll < 40)
               c.status = TS_STOPPED;
            else if (roll < 70)
               c.status = TS_ACTIVE;
            else if (roll < 85)
               c.status = TS_WAIT;
            else if (roll < 93)
               c.status = TS_SUSPEND;
            else
               c.status = 3'($urandom_range(STATE_MAX_CODE, TS_STOPPED + 3'd1));
         end else if (roll < 95) begin
            c.kind = KIND_CREATE;
         end else begin
            c.kind = 3'($urandom_range(KIND_MAX_CODE, KIND_TICK + 3'd1));
         end
         commands_to_send.push_back(c);
         counted++;
      end

      while (reset || commands_to_send.size() != 0 || start || outcomes_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outcomes_due.size() == 0)
         $display("PASS decaying_priority_task_scheduler");
      else
         $display("FAIL decaying_priority_task_scheduler");
      $finish;
   end

endmodule

/* filelist.f */
rtl/dpts_pkg.sv
rtl/dpts_cell.sv
rtl/decaying_priority_task_scheduler.sv
rtl/dpts_checker.sv
bench/testbench.sv
